// ===== sv/depth_or_disparity_to_xyz_top_defines.svh =====
// Assertion macros for the range-to-point block checker.
// Used by dtx_checker; no other dependencies.
`ifndef DEPTH_OR_DISPARITY_TO_XYZ_TOP_DEFINES_SVH
`define DEPTH_OR_DISPARITY_TO_XYZ_TOP_DEFINES_SVH

// clocked check, disabled during reset
`define DTX_CHECK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked check that also holds in reset
`define DTX_CHECK_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/dtx_pkg.sv =====
// Shared types and constants of the range-to-point block.
// No dependencies.
`timescale 1ns / 1ps
package dtx_pkg;
   localparam int unsigned VW = 49;   // scaled value width when positive
   localparam int unsigned ZQ = 63;   // disparity quotient bits below the cap
   localparam int unsigned PQ = 32;   // projection quotient bits

   localparam logic [2:0] REG_MODE   = 3'd0;
   localparam logic [2:0] REG_SCALE  = 3'd1;
   localparam logic [2:0] REG_OFFSET = 3'd2;
   localparam logic [2:0] REG_FOCAL  = 3'd3;
   localparam logic [2:0] REG_PU     = 3'd4;
   localparam logic [2:0] REG_PV     = 3'd5;
   localparam logic [2:0] REG_BASE   = 3'd6;

   localparam logic [31:0] SCALE_RESET = 32'h0100_0000;
   localparam logic [31:0] POS_MAX     = 32'h7FFF_FFFF;
   localparam logic [31:0] NEG_MAX     = 32'h8000_0000;

   typedef struct packed {
      logic        mode;
      logic [31:0] scale;
      logic [31:0] offset;
      logic [31:0] focal;
      logic [31:0] pu;
      logic [31:0] pv;
      logic [31:0] base;
   } cfg_type;

   typedef struct packed {
      logic        inval;
      logic        bigd;
      logic [40:0] zdep;
      logic [31:0] magx;
      logic [31:0] magy;
      logic        negx;
      logic        negy;
   } zside_type;

   typedef struct packed {
      logic        inval;
      logic        negx;
      logic        bigx;
      logic [31:0] zval;
      logic        zsat;
   } xside_type;

   typedef struct packed {
      logic negy;
      logic bigy;
   } yside_type;
endpackage

// ===== sv/dtx_if.sv =====
// Valid/ready channel interfaces for pixel requests and point responses.
// No dependencies.
`timescale 1ns / 1ps
interface dtx_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] raw_value;
   logic [11:0] column;
   logic [11:0] pixel_row;
   modport source (output valid, raw_value, column, pixel_row, input ready);
   modport sink (input valid, raw_value, column, pixel_row, output ready);
endinterface

interface dtx_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] point_x;
   logic signed [31:0] point_y;
   logic signed [31:0] point_z;
   logic               point_valid;
   logic               saturated;
   modport source (output valid, point_x, point_y, point_z, point_valid, saturated,
                   input ready);
   modport sink (input valid, point_x, point_y, point_z, point_valid, saturated,
                 output ready);
endinterface

// ===== sv/dtx_udiv.sv =====
// Pipelined restoring unsigned divider, one quotient bit per stage.
// Depends on nothing; carries a sideband vector alongside the data.
`timescale 1ns / 1ps
module dtx_udiv #(
   parameter int unsigned DW = 32,
   parameter int unsigned QB = 32,
   parameter int unsigned SW = 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          en,
   input  logic          in_vld,
   input  logic [DW-1:0] in_rem,
   input  logic [QB-1:0] in_num,
   input  logic [DW-1:0] in_den,
   input  logic [SW-1:0] in_side,
   output logic          out_vld,
   output logic [QB-1:0] out_quo,
   output logic [SW-1:0] out_side
);
   logic          vld_ff  [QB+1];
   logic [DW-1:0] rem_ff  [QB+1];
   logic [QB-1:0] lq_ff   [QB+1];
   logic [DW-1:0] den_ff  [QB+1];
   logic [SW-1:0] side_ff [QB+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= QB; i++) vld_ff[i] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= in_vld;
         for (int i = 1; i <= QB; i++) vld_ff[i] <= vld_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0]  <= in_rem;
         lq_ff[0]   <= in_num;
         den_ff[0]  <= in_den;
         side_ff[0] <= in_side;
      end
   end

   for (genvar k = 0; k < QB; k++) begin : g_stage
      logic [DW:0]   r2;
      logic [DW:0]   diff;
      logic          ge;
      logic [DW-1:0] rem_in;
      logic [QB-1:0] lq_in;
      always_comb begin
         r2     = {rem_ff[k], lq_ff[k][QB-1]};
         diff   = r2 - {1'b0, den_ff[k]};
         ge     = r2 >= {1'b0, den_ff[k]};
         rem_in = ge ? diff[DW-1:0] : r2[DW-1:0];
         lq_in  = {lq_ff[k][QB-2:0], ge};
      end
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k+1]  <= rem_in;
            lq_ff[k+1]   <= lq_in;
            den_ff[k+1]  <= den_ff[k];
            side_ff[k+1] <= side_ff[k];
         end
      end
   end

   assign out_vld  = vld_ff[QB];
   assign out_quo  = lq_ff[QB];
   assign out_side = side_ff[QB];
endmodule

// ===== sv/dtx_csr.sv =====
// APB-style register file of the range-to-point block.
// Depends on dtx_pkg.
`timescale 1ns / 1ps
module dtx_csr
   import dtx_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [4:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output cfg_type     cfg
);
   cfg_type    cfg_ff;
   logic [2:0] idx;
   logic       wr;

   assign idx = paddr[4:2];
   assign wr  = psel & penable & pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{mode: 1'b0, scale: SCALE_RESET, offset: '0, focal: '0, pu: '0,
                     pv: '0, base: '0};
      end else if (wr) begin
         case (idx)
            REG_MODE:   cfg_ff.mode   <= pwdata[0];
            REG_SCALE:  cfg_ff.scale  <= pwdata;
            REG_OFFSET: cfg_ff.offset <= pwdata;
            REG_FOCAL:  cfg_ff.focal  <= pwdata;
            REG_PU:     cfg_ff.pu     <= pwdata;
            REG_PV:     cfg_ff.pv     <= pwdata;
            REG_BASE:   cfg_ff.base   <= pwdata;
            default:    ;
         endcase
      end
   end

   always_comb begin
      case (idx)
         REG_MODE:   prdata = {31'b0, cfg_ff.mode};
         REG_SCALE:  prdata = cfg_ff.scale;
         REG_OFFSET: prdata = cfg_ff.offset;
         REG_FOCAL:  prdata = cfg_ff.focal;
         REG_PU:     prdata = cfg_ff.pu;
         REG_PV:     prdata = cfg_ff.pv;
         REG_BASE:   prdata = cfg_ff.base;
         default:    prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;
endmodule

// ===== sv/depth_or_disparity_to_xyz_top.sv =====
// Top level of the range-to-point block: registers, scaling, depth and projection pipeline.
// Depends on dtx_pkg, dtx_if, dtx_csr and dtx_udiv.
`timescale 1ns / 1ps
// Takes one range pixel per clock unless the output stalls and returns one Q16.16 point per
// pixel, in order. It has 103 register stages: two scaling stages, a 64-stage pipelined
// divider for disparity-to-depth, three multiply and select stages, a 33-stage divider for
// the X/Y projection and the output register. A stall on the response side holds the
// whole pipeline; req.ready follows rsp.ready whenever the output register is full.
module depth_or_disparity_to_xyz_top
   import dtx_pkg::*;
#(
   parameter int unsigned COORD_BITS = 12
) (
   input  logic        clock,
   input  logic        reset,
   dtx_req_if.sink     req,
   dtx_rsp_if.source   rsp,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   localparam int unsigned CW = (COORD_BITS < 12) ? COORD_BITS : 12;

   cfg_type cfg;
   logic    adv;

   dtx_csr u_csr (
      .clock(clock), .reset(reset), .psel(csr_psel), .penable(csr_penable),
      .pwrite(csr_pwrite), .paddr(csr_paddr), .pwdata(csr_pwdata),
      .prdata(csr_prdata), .cfg(cfg)
   );
   assign csr_pready = 1'b1;

   logic out_vld_ff;
   assign adv       = ~out_vld_ff | rsp.ready;
   assign req.ready = adv;

   // stage 1: product and coordinate offsets
   logic        s1_vld_ff;
   logic [47:0] s1_prod_ff;
   logic        s1_rawz_ff;
   logic [32:0] s1_dux_ff, s1_duy_ff;
   logic [15:0] colx, rowx;

   assign colx = {{(16-CW){1'b0}}, req.column[CW-1:0]};
   assign rowx = {{(16-CW){1'b0}}, req.pixel_row[CW-1:0]};

   always_ff @(posedge clock) begin
      if (reset) s1_vld_ff <= 1'b0;
      else if (adv) s1_vld_ff <= req.valid;
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         s1_prod_ff <= {32'b0, req.raw_value} * {16'b0, cfg.scale};
         s1_rawz_ff <= req.raw_value == 16'd0;
         s1_dux_ff  <= {1'b0, colx, 16'b0} - {1'b0, cfg.pu};
         s1_duy_ff  <= {1'b0, rowx, 16'b0} - {1'b0, cfg.pv};
      end
   end

   // stage 2: scaled value, validity, baseline times focal
   logic        s2_vld_ff;
   logic [48:0] s2_v_ff;
   logic        s2_inval_ff;
   logic [63:0] s2_bf_ff;
   logic [31:0] s2_magx_ff, s2_magy_ff;
   logic        s2_negx_ff, s2_negy_ff;
   logic [49:0] v_in;
   logic [32:0] nx, ny;

   assign v_in = {2'b0, s1_prod_ff} + {{10{cfg.offset[31]}}, cfg.offset, 8'b0};
   assign nx   = 33'd0 - s1_dux_ff;
   assign ny   = 33'd0 - s1_duy_ff;

   always_ff @(posedge clock) begin
      if (reset) s2_vld_ff <= 1'b0;
      else if (adv) s2_vld_ff <= s1_vld_ff;
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         s2_v_ff     <= v_in[48:0];
         s2_inval_ff <= s1_rawz_ff | v_in[49] | (v_in == 50'd0) | (cfg.focal == 32'd0);
         s2_bf_ff    <= {32'b0, cfg.base} * {32'b0, cfg.focal};
         s2_negx_ff  <= s1_dux_ff[32];
         s2_negy_ff  <= s1_duy_ff[32];
         s2_magx_ff  <= s1_dux_ff[32] ? nx[31:0] : s1_dux_ff[31:0];
         s2_magy_ff  <= s1_duy_ff[32] ? ny[31:0] : s1_duy_ff[31:0];
      end
   end

   // disparity divide
   logic [72:0] nd;
   logic [49:0] zr;
   zside_type   zs_in, zs_out;
   logic        zd_vld;
   logic [ZQ-1:0] zq;

   assign nd = {1'b0, s2_bf_ff, 8'b0} + {25'b0, s2_v_ff[48:1]};
   assign zr = {1'b0, s2_v_ff} + 50'd128;
   always_comb begin
      zs_in.inval = s2_inval_ff;
      zs_in.bigd  = {39'b0, nd[72:63]} >= s2_v_ff;
      zs_in.zdep  = zr[48:8];
      zs_in.magx  = s2_magx_ff;
      zs_in.magy  = s2_magy_ff;
      zs_in.negx  = s2_negx_ff;
      zs_in.negy  = s2_negy_ff;
   end

   dtx_udiv #(.DW(VW), .QB(ZQ), .SW($bits(zside_type))) u_zdiv (
      .clock(clock), .reset(reset), .en(adv), .in_vld(s2_vld_ff),
      .in_rem({39'b0, nd[72:63]}), .in_num(nd[62:0]), .in_den(s2_v_ff),
      .in_side(zs_in), .out_vld(zd_vld), .out_quo(zq), .out_side(zs_out)
   );

   // depth select
   logic        sz_vld_ff;
   logic [63:0] sz_z_ff;
   zside_type   sz_side_ff;

   always_ff @(posedge clock) begin
      if (reset) sz_vld_ff <= 1'b0;
      else if (adv) sz_vld_ff <= zd_vld;
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         sz_side_ff <= zs_out;
         if (!cfg.mode) sz_z_ff <= {23'b0, zs_out.zdep};
         else if (zs_out.bigd) sz_z_ff <= {1'b1, 63'b0};
         else sz_z_ff <= {1'b0, zq};
      end
   end

   // multiply
   logic        m1_vld_ff;
   logic [63:0] m1_xlo_ff, m1_xhi_ff, m1_ylo_ff, m1_yhi_ff;
   xside_type   m1_xs_ff;
   yside_type   m1_ys_ff;

   always_ff @(posedge clock) begin
      if (reset) m1_vld_ff <= 1'b0;
      else if (adv) m1_vld_ff <= sz_vld_ff;
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         m1_xlo_ff      <= {32'b0, sz_side_ff.magx} * {32'b0, sz_z_ff[31:0]};
         m1_xhi_ff      <= {32'b0, sz_side_ff.magx} * {32'b0, sz_z_ff[63:32]};
         m1_ylo_ff      <= {32'b0, sz_side_ff.magy} * {32'b0, sz_z_ff[31:0]};
         m1_yhi_ff      <= {32'b0, sz_side_ff.magy} * {32'b0, sz_z_ff[63:32]};
         m1_xs_ff.inval <= sz_side_ff.inval;
         m1_xs_ff.negx  <= sz_side_ff.negx;
         m1_xs_ff.bigx  <= 1'b0;
         m1_xs_ff.zsat  <= sz_z_ff[63:31] != 33'd0;
         m1_xs_ff.zval  <= (sz_z_ff[63:31] != 33'd0) ? POS_MAX : sz_z_ff[31:0];
         m1_ys_ff.negy  <= sz_side_ff.negy;
         m1_ys_ff.bigy  <= 1'b0;
      end
   end

   // numerator sums
   logic        m2_vld_ff;
   logic [95:0] m2_nx_ff, m2_ny_ff;
   xside_type   m2_xs_ff;
   yside_type   m2_ys_ff;
   logic [95:0] half_f;

   assign half_f = {65'b0, cfg.focal[31:1]};
   always_ff @(posedge clock) begin
      if (reset) m2_vld_ff <= 1'b0;
      else if (adv) m2_vld_ff <= m1_vld_ff;
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         m2_nx_ff <= {m1_xhi_ff, 32'b0} + {32'b0, m1_xlo_ff} + half_f;
         m2_ny_ff <= {m1_yhi_ff, 32'b0} + {32'b0, m1_ylo_ff} + half_f;
         m2_xs_ff <= m1_xs_ff;
         m2_ys_ff <= m1_ys_ff;
      end
   end

   // projection divide
   xside_type xs_in, xs_out;
   yside_type ys_in, ys_out;
   logic      xd_vld, yd_vld;
   logic [PQ-1:0] qx, qy;

   always_comb begin
      xs_in      = m2_xs_ff;
      xs_in.bigx = m2_nx_ff[95:32] >= {32'b0, cfg.focal};
      ys_in      = m2_ys_ff;
      ys_in.bigy = m2_ny_ff[95:32] >= {32'b0, cfg.focal};
   end

   dtx_udiv #(.DW(32), .QB(PQ), .SW($bits(xside_type))) u_xdiv (
      .clock(clock), .reset(reset), .en(adv), .in_vld(m2_vld_ff),
      .in_rem(m2_nx_ff[63:32]), .in_num(m2_nx_ff[31:0]), .in_den(cfg.focal),
      .in_side(xs_in), .out_vld(xd_vld), .out_quo(qx), .out_side(xs_out)
   );
   dtx_udiv #(.DW(32), .QB(PQ), .SW($bits(yside_type))) u_ydiv (
      .clock(clock), .reset(reset), .en(adv), .in_vld(m2_vld_ff),
      .in_rem(m2_ny_ff[63:32]), .in_num(m2_ny_ff[31:0]), .in_den(cfg.focal),
      .in_side(ys_in), .out_vld(yd_vld), .out_quo(qy), .out_side(ys_out)
   );

   function automatic logic [32:0] clip(input logic [31:0] q, input logic big,
                                        input logic neg);
      logic [31:0] nq;
      nq = 32'd0 - q;
      if (neg) begin
         if (big || q > NEG_MAX) clip = {1'b1, NEG_MAX};
         else clip = {1'b0, nq};
      end else begin
         if (big || q[31]) clip = {1'b1, POS_MAX};
         else clip = {1'b0, q};
      end
   endfunction

   // output register
   logic [32:0] cx, cy;
   logic [31:0] ox_ff, oy_ff, oz_ff;
   logic        opv_ff, osat_ff;

   assign cx = clip(qx, xs_out.bigx, xs_out.negx);
   assign cy = clip(qy, ys_out.bigy, ys_out.negy);

   always_ff @(posedge clock) begin
      if (reset) out_vld_ff <= 1'b0;
      else if (adv) out_vld_ff <= xd_vld & yd_vld;
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         if (xs_out.inval) begin
            ox_ff   <= '0;
            oy_ff   <= '0;
            oz_ff   <= '0;
            opv_ff  <= 1'b0;
            osat_ff <= 1'b0;
         end else begin
            ox_ff   <= cx[31:0];
            oy_ff   <= cy[31:0];
            oz_ff   <= xs_out.zval;
            opv_ff  <= 1'b1;
            osat_ff <= cx[32] | cy[32] | xs_out.zsat;
         end
      end
   end

   assign rsp.valid       = out_vld_ff;
   assign rsp.point_x     = ox_ff;
   assign rsp.point_y     = oy_ff;
   assign rsp.point_z     = oz_ff;
   assign rsp.point_valid = opv_ff;
   assign rsp.saturated   = osat_ff;
endmodule

// ===== sv/dtx_checker.sv =====
// Port-level checks of the range-to-point block, bound to the top level.
// Depends on depth_or_disparity_to_xyz_top_defines.svh.
`timescale 1ns / 1ps
`include "depth_or_disparity_to_xyz_top_defines.svh"
module dtx_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] point_x,
   input logic [31:0] point_y,
   input logic [31:0] point_z,
   input logic        point_valid,
   input logic        saturated,
   input logic        csr_pready
);
   `DTX_CHECK(a_inval_zero, clock, reset, (rsp_valid && !point_valid) |-> (point_x == 32'd0 && point_y == 32'd0 && point_z == 32'd0 && !saturated), "invalid point not zeroed")
   `DTX_CHECK(a_z_nonneg, clock, reset, (rsp_valid && point_valid) |-> !point_z[31], "negative depth")
   `DTX_CHECK(a_stall_ready, clock, reset, (rsp_valid && !rsp_ready) |-> !req_ready, "transfer taken while output stalled")
   `DTX_CHECK(a_rsp_hold, clock, reset, (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(point_x) && $stable(point_z)), "stalled response changed")
   `DTX_CHECK_ALWAYS(a_pready, clock, csr_pready, "pready low")
endmodule

bind depth_or_disparity_to_xyz_top dtx_checker u_dtx_checker (
   .clock(clock), .reset(reset),
   .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
   .point_x(rsp.point_x), .point_y(rsp.point_y), .point_z(rsp.point_z),
   .point_valid(rsp.point_valid), .saturated(rsp.saturated),
   .csr_pready(csr_pready)
);

// ===== bench/dtx_checker.sv =====
// Checker for the range-to-point block: mirrors the CSR writes, predicts each point
// and compares responses in order. Depends on dtx_pkg and dtx_if.
`timescale 1ns / 1ps
module dtx_scoreboard
   import dtx_pkg::*;
#(
   parameter int unsigned COORD_BITS = 12
) (
   input  logic        clock,
   input  logic        reset,
   dtx_req_if          req,
   dtx_rsp_if          rsp,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   input  logic        csr_pready,
   output int          fail_count,
   output int          pending
);
   localparam logic [63:0] DEPTH_CAP = 64'h8000_0000_0000_0000;

   typedef struct {
      logic [31:0] x;
      logic [31:0] y;
      logic [31:0] z;
      logic        ok;
      logic        sat;
   } point_type;

   cfg_type   regs;
   point_type expected_points[$];

   assign pending = expected_points.size();

   function automatic logic [31:0] clip_coord(logic [63:0] mag, logic neg, inout logic sat);
      if (neg) begin
         if (mag > 64'h8000_0000) begin
            sat = 1'b1;
            return NEG_MAX;
         end
         return 32'(-mag);
      end
      if (mag > 64'h7FFF_FFFF) begin
         sat = 1'b1;
         return POS_MAX;
      end
      return mag[31:0];
   endfunction

   function automatic logic [31:0] back_project(logic [11:0] coord, logic [31:0] principal,
                                                logic [63:0] depth, inout logic sat);
      logic [63:0]     cmask;
      longint          du;
      logic            neg;
      logic [63:0]     mag;
      logic [127:0]    num;
      logic [127:0]    quo;
      cmask = (64'd1 << COORD_BITS) - 64'd1;
      du    = longint'((64'(coord) & cmask) << 16) - longint'({32'd0, principal});
      neg   = du < 0;
      mag   = neg ? 64'(-du) : 64'(du);
      num   = {64'd0, mag} * {64'd0, depth} + 128'(regs.focal >> 1);
      quo   = num / {96'd0, regs.focal};
      if (quo > {64'd0, DEPTH_CAP})
         quo = {64'd0, DEPTH_CAP};
      return clip_coord(quo[63:0], neg, sat);
   endfunction

   function automatic point_type predict_point(logic [15:0] raw, logic [11:0] col,
                                               logic [11:0] row);
      point_type    p;
      longint       scaled;
      logic [63:0]  depth;
      logic [127:0] num;
      logic [127:0] quo;
      logic         sat;
      p      = '{default: '0};
      sat    = 1'b0;
      scaled = longint'(64'(raw) * 64'(regs.scale)) + (longint'($signed(regs.offset)) <<< 8);
      if (raw == 16'd0 || scaled <= 0 || regs.focal == 32'd0)
         return p;
      if (regs.mode) begin
         num = {96'd0, regs.base} * {96'd0, regs.focal} * 128'd256
               + 128'(64'(scaled) >> 1);
         quo = num / {64'd0, 64'(scaled)};
         depth = (quo > {64'd0, DEPTH_CAP}) ? DEPTH_CAP : quo[63:0];
      end else begin
         depth = (64'(scaled) + 64'd128) >> 8;
      end
      p.x   = back_project(col, regs.pu, depth, sat);
      p.y   = back_project(row, regs.pv, depth, sat);
      p.z   = clip_coord(depth, 1'b0, sat);
      p.ok  = 1'b1;
      p.sat = sat;
      return p;
   endfunction

   always @(posedge clock) begin
      point_type e;
      if (reset) begin
         regs.mode   <= 1'b0;
         regs.scale  <= SCALE_RESET;
         regs.offset <= '0;
         regs.focal  <= '0;
         regs.pu     <= '0;
         regs.pv     <= '0;
         regs.base   <= '0;
         fail_count  <= 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[4:2])
               REG_MODE:   regs.mode   <= csr_pwdata[0];
               REG_SCALE:  regs.scale  <= csr_pwdata;
               REG_OFFSET: regs.offset <= csr_pwdata;
               REG_FOCAL:  regs.focal  <= csr_pwdata;
               REG_PU:     regs.pu     <= csr_pwdata;
               REG_PV:     regs.pv     <= csr_pwdata;
               REG_BASE:   regs.base   <= csr_pwdata;
               default: ;
            endcase
         end
         if (rsp.valid && rsp.ready) begin
            if (expected_points.size() == 0) begin
               $display("%0t unexpected point transfer: x=%h y=%h z=%h v=%b s=%b", $time,
                        rsp.point_x, rsp.point_y, rsp.point_z, rsp.point_valid,
                        rsp.saturated);
               fail_count <= fail_count + 1;
            end else begin
               e = expected_points.pop_front();
               if (rsp.point_x !== e.x || rsp.point_y !== e.y || rsp.point_z !== e.z ||
                   rsp.point_valid !== e.ok || rsp.saturated !== e.sat) begin
                  $display("%0t point mismatch: expected x=%h y=%h z=%h v=%b s=%b", $time,
                           e.x, e.y, e.z, e.ok, e.sat);
                  $display("%0t                 actual   x=%h y=%h z=%h v=%b s=%b", $time,
                           rsp.point_x, rsp.point_y, rsp.point_z, rsp.point_valid,
                           rsp.saturated);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req.valid && req.ready)
            expected_points.push_back(predict_point(req.raw_value, req.column, req.pixel_row));
      end
   end
endmodule

// ===== bench/tb_top.sv =====
// Testbench top for the range-to-point block: clock, reset, CSR phases, pixel stimulus
// with random gaps and response stalls, watchdog and verdict. Depends on dtx_pkg,
// dtx_if, dtx_scoreboard and depth_or_disparity_to_xyz_top.
`timescale 1ns / 1ps
module tb_top;
   import dtx_pkg::*;

   localparam int WATCHDOG_LIMIT = 3000;
   localparam int DRAIN_CYCLES   = 200;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [4:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;
   int          fail_count;
   int          pending;
   int          idle_cycles = 0;
   int          stall_left = 0;
   bit          quiet = 1'b0;

   dtx_req_if req ();
   dtx_rsp_if rsp ();

   initial begin
      req.valid     = 1'b0;
      req.raw_value = '0;
      req.column    = '0;
      req.pixel_row = '0;
      rsp.ready     = 1'b0;
   end

   always #2 clock = ~clock;

   depth_or_disparity_to_xyz_top dut (
      .clock, .reset, .req, .rsp, .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr,
      .csr_pwdata, .csr_prdata, .csr_pready
   );

   dtx_scoreboard u_checker (
      .clock, .reset, .req, .rsp, .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr,
      .csr_pwdata, .csr_pready, .fail_count, .pending
   );

   function automatic int pick_gap();
      int r;
      r = $urandom_range(99);
      if (quiet || r < 60)
         return 0;
      if (r < 93)
         return $urandom_range(3, 1);
      return $urandom_range(40, 10);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
      end else if (stall_left > 0) begin
         rsp.ready  <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         rsp.ready  <= 1'b1;
         stall_left <= pick_gap();
      end
   end

   always @(posedge clock) begin
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || csr_psel || reset) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   task automatic write_reg(logic [2:0] index, logic [31:0] data);
      @(posedge clock);
      csr_psel   <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr  <= {index, 2'b00};
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic load_config(cfg_type c);
      write_reg(REG_MODE, {31'd0, c.mode});
      write_reg(REG_SCALE, c.scale);
      write_reg(REG_OFFSET, c.offset);
      write_reg(REG_FOCAL, c.focal);
      write_reg(REG_PU, c.pu);
      write_reg(REG_PV, c.pv);
      write_reg(REG_BASE, c.base);
   endtask

   task automatic send_pixel(logic [15:0] raw, logic [11:0] col, logic [11:0] row);
      int g;
      req.valid     <= 1'b1;
      req.raw_value <= raw;
      req.column    <= col;
      req.pixel_row <= row;
      do @(posedge clock); while (!req.ready);
      g = pick_gap();
      if (g > 0) begin
         req.valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
   endtask

   task automatic finish_phase();
      req.valid <= 1'b0;
      while (pending != 0) @(posedge clock);
   endtask

   task automatic send_random(int count);
      logic [15:0] raw;
      repeat (count) begin
         case ($urandom_range(15))
            0:       raw = 16'h0000;
            1:       raw = 16'hFFFF;
            2, 3:    raw = 16'($urandom_range(255, 1));
            default: raw = 16'($urandom);
         endcase
         send_pixel(raw, 12'($urandom), 12'($urandom));
      end
   endtask

   function automatic cfg_type random_config();
      cfg_type c;
      c.mode   = 1'($urandom);
      c.scale  = $urandom_range(3) == 0 ? $urandom : $urandom_range(32'h0200_0000, 32'h0001_0000);
      c.offset = $urandom_range(3) == 0 ? $urandom : 32'($signed($urandom_range(2000)) - 1000)
                                                      <<< 16;
      c.focal  = $urandom_range(9) == 0 ? 32'd0 :
                 $urandom_range(3) == 0 ? $urandom : $urandom_range(2000 << 16, 100 << 16);
      c.pu     = $urandom_range(3) == 0 ? $urandom : $urandom_range(4095 << 16);
      c.pv     = $urandom_range(3) == 0 ? $urandom : $urandom_range(4095 << 16);
      c.base   = $urandom_range(3) == 0 ? $urandom : $urandom_range(500 << 16);
      return c;
   endfunction

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset values: zero focal length, so every point is invalid
      send_pixel(16'd1000, 12'd10, 12'd20);
      send_pixel(16'hFFFF, 12'hFFF, 12'hFFF);
      finish_phase();

      load_config('{1'b0, 32'h0100_0000, 32'd0, 32'd500 << 16, 32'd320 << 16,
                    32'd240 << 16, 32'd0});
      send_pixel(16'h0000, 12'd5, 12'd5);
      send_pixel(16'h0001, 12'h000, 12'h000);
      send_pixel(16'hFFFF, 12'hFFF, 12'hFFF);
      send_pixel(16'd1500, 12'd320, 12'd240);
      send_pixel(16'd800, 12'hFFF, 12'h000);
      send_pixel(16'd800, 12'h000, 12'hFFF);
      finish_phase();

      // disparity mode, regular stereo geometry
      load_config('{1'b1, 32'h0010_0000, 32'd0, 32'd700 << 16, 32'd640 << 16,
                    32'd360 << 16, 32'd120 << 16});
      send_pixel(16'h0001, 12'd0, 12'd0);
      send_pixel(16'd16, 12'hFFF, 12'hFFF);
      send_pixel(16'hFFFF, 12'd640, 12'd360);
      send_pixel(16'd1000, 12'd100, 12'd900);
      finish_phase();

      // zero baseline gives valid points at zero depth
      load_config('{1'b1, 32'h0100_0000, 32'd0, 32'd700 << 16, 32'd640 << 16,
                    32'd360 << 16, 32'd0});
      send_pixel(16'd50, 12'd1, 12'd2);
      send_pixel(16'hFFFF, 12'hFFF, 12'hFFF);
      finish_phase();

      // largest values in all registers but pv: large depths, some outputs saturate
      load_config('{1'b1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                    32'd0, 32'hFFFF_FFFF});
      send_pixel(16'h0001, 12'h000, 12'hFFF);
      send_pixel(16'hFFFF, 12'hFFF, 12'h000);
      finish_phase();

      // most negative offset and zero scale: scaled value never positive
      load_config('{1'b0, 32'd0, 32'h8000_0000, 32'd1, 32'd0, 32'hFFFF_FFFF, 32'd0});
      send_pixel(16'hFFFF, 12'hFFF, 12'hFFF);
      send_pixel(16'h0001, 12'd0, 12'd0);
      finish_phase();

      // unit focal length in depth mode clips X and Y
      load_config('{1'b0, 32'hFFFF_FFFF, 32'd0, 32'd1, 32'd0, 32'hFFFF_FFFF, 32'd0});
      send_pixel(16'hFFFF, 12'hFFF, 12'h000);
      send_pixel(16'h0001, 12'h001, 12'h001);
      finish_phase();

      for (int phase = 0; phase < 10; phase++) begin
         quiet = (phase % 4) == 3;
         load_config(random_config());
         send_random(65);
         finish_phase();
      end
      quiet = 1'b0;

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end
endmodule

// ===== depth_or_disparity_to_xyz_top.f =====
+incdir+sv
sv/dtx_pkg.sv
sv/dtx_if.sv
sv/dtx_udiv.sv
sv/dtx_csr.sv
sv/depth_or_disparity_to_xyz_top.sv
sv/dtx_checker.sv
bench/dtx_checker.sv
bench/tb_top.sv
